### hw/rtl/vpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned MaxSegmentsDef = 32;
  localparam int unsigned AddrWidthDef   = 16;

  localparam int unsigned LenW    = 16;
  localparam int unsigned OwnerW  = 8;
  localparam int unsigned PIdxW   = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PolicyW = 2;

  localparam logic [LenW-1:0] TotalSizeRst = 16'hFFFF;

  // Register indexes of the write port.
  localparam logic RegTotalSize = 1'b0;
  localparam logic RegFitPolicy = 1'b1;

  // Operation codes.
  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  // Fit policies; the unused code behaves as first fit.
  localparam logic [PolicyW-1:0] PolFirst = 2'd0;
  localparam logic [PolicyW-1:0] PolBest  = 2'd1;
  localparam logic [PolicyW-1:0] PolWorst = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoFit    = 3'd1;
  localparam logic [StatusW-1:0] StFull     = 3'd2;
  localparam logic [StatusW-1:0] StBadIndex = 3'd3;
  localparam logic [StatusW-1:0] StFree     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHUP,
    S_SPLIT,
    S_WRPICK,
    S_RCUR,
    S_RNXT,
    S_RPRV,
    S_MERGE,
    S_SHDN
  } state_e;

endpackage

### hw/rtl/vpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/variable_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Address-ordered segment table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Sequence: allocate scans every entry, then decides; a split first shifts
//   the upper entries up. Release reads the entry and its neighbors, then
//   merges and may shift the upper entries down to compact the table.
//   Rejections right at accept raise done_o in the cycle after accept.
// Throughput: one transaction at a time; the single table read port walks
//   one entry per cycle for scan and shift.
// Reset: table holds one free segment of total_size; busy_o is high for
//   one cycle after reset and idle total_size writes, as entry 0 is set up.
// The receiver cannot stall: done_o pulses for one cycle per transaction.
module variable_partition_allocator #(
  parameter int unsigned MAX_SEGMENTS = vpa_pkg::MaxSegmentsDef,
  parameter int unsigned ADDR_WIDTH   = vpa_pkg::AddrWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [vpa_pkg::LenW-1:0]      cfg_data_i,
  // Command
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          operation_i,
  input  logic [vpa_pkg::LenW-1:0]      request_length_i,
  input  logic [vpa_pkg::OwnerW-1:0]    owner_id_i,
  input  logic [vpa_pkg::PIdxW-1:0]     partition_index_i,
  // Result
  output logic                          done_o,
  output logic [vpa_pkg::StatusW-1:0]   status_o,
  output logic [vpa_pkg::PIdxW-1:0]     segment_index_o,
  output logic [vpa_pkg::LenW-1:0]      segment_start_o,
  output logic [vpa_pkg::LenW-1:0]      segment_length_o
);

  localparam int unsigned AW   = ADDR_WIDTH;
  localparam int unsigned IW   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned CW   = (AW > vpa_pkg::LenW) ? AW : vpa_pkg::LenW;
  localparam int unsigned XW   = (CNTW > vpa_pkg::PIdxW) ? CNTW : vpa_pkg::PIdxW;
  localparam int unsigned OW   = vpa_pkg::OwnerW;
  // Entry layout: {owner, busy, length, start}
  localparam int unsigned EW   = 2 * AW + 1 + OW;

  vpa_pkg::state_e state_q, state_d;

  // Configuration
  logic [AW-1:0]               total_q;
  logic [vpa_pkg::PolicyW-1:0] policy_q;
  logic                        init_q, init_d;

  // Table bookkeeping
  logic [CNTW-1:0] count_q, count_d;

  // Transaction context
  logic [vpa_pkg::LenW-1:0] req_q, req_d;
  logic [OW-1:0]            owner_q, owner_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic [IW-1:0]            k_q, k_d;
  logic                     found_q, found_d;
  logic [IW-1:0]            pick_q, pick_d;
  logic [AW-1:0]            bstart_q, bstart_d;
  logic [AW-1:0]            blen_q, blen_d;
  logic [AW-1:0]            cstart_q, cstart_d;
  logic [AW-1:0]            clen_q, clen_d;
  logic                     nb_q, nb_d;
  logic [AW-1:0]            nlen_q, nlen_d;
  logic                     pb_q, pb_d;
  logic [AW-1:0]            plen_q, plen_d;
  logic [AW-1:0]            pstart_q, pstart_d;
  logic [1:0]               r_q, r_d;

  // Result registers
  logic                          done_q, done_d;
  logic [vpa_pkg::StatusW-1:0]   st_q, st_d;
  logic [vpa_pkg::PIdxW-1:0]     sidx_q, sidx_d;
  logic [vpa_pkg::LenW-1:0]      sstart_q, sstart_d;
  logic [vpa_pkg::LenW-1:0]      slen_q, slen_d;

  // RAM port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [AW-1:0] r_start, r_len;
  logic          r_busy;
  logic          take;
  logic          accept;
  logic [CW-1:0] reqx;
  logic [AW-1:0] mlen;
  logic [CNTW-1:0] sh_src;
  logic [CNTW-1:0] last_idx;

  vpa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign r_start  = rdata[AW-1:0];
  assign r_len    = rdata[2*AW-1:AW];
  assign r_busy   = rdata[2*AW];
  assign reqx     = CW'(req_q);
  assign last_idx = count_q - 1'b1;
  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != vpa_pkg::S_IDLE) || init_q;

  // Merged length of a release: current plus free neighbors, wrapping.
  always_comb begin
    mlen = nb_q ? AW'(clen_q + nlen_q) : clen_q;
    if (pb_q) begin
      mlen = AW'(plen_q + mlen);
    end
  end
  assign sh_src = CNTW'(idx_q) + CNTW'(1) + CNTW'(nb_q);

  // Scan candidate selection
  always_comb begin
    take = 1'b0;
    if (!r_busy) begin
      if (policy_q == vpa_pkg::PolWorst) begin
        take = !found_q || (r_len > blen_q);
      end else if (CW'(r_len) >= reqx) begin
        take = !found_q || ((policy_q == vpa_pkg::PolBest) && (r_len < blen_q));
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vpa_pkg::S_IDLE: begin
        if (accept) begin
          if (operation_i == vpa_pkg::OpAlloc) begin
            if (request_length_i != '0) state_d = vpa_pkg::S_SCAN;
          end else if (XW'(partition_index_i) < XW'(count_q)) begin
            state_d = vpa_pkg::S_RCUR;
          end
        end
      end
      vpa_pkg::S_SCAN: begin
        if (CNTW'(k_q) == last_idx) state_d = vpa_pkg::S_DECIDE;
      end
      vpa_pkg::S_DECIDE: begin
        if (!found_q || (CW'(blen_q) < reqx)) begin
          state_d = vpa_pkg::S_IDLE;
        end else if (CW'(blen_q) > reqx) begin
          if (count_q >= CNTW'(MAX_SEGMENTS)) state_d = vpa_pkg::S_IDLE;
          else if (last_idx > CNTW'(pick_q)) state_d = vpa_pkg::S_SHUP;
          else state_d = vpa_pkg::S_SPLIT;
        end else begin
          state_d = vpa_pkg::S_WRPICK;
        end
      end
      vpa_pkg::S_SHUP: begin
        if (k_q == IW'(pick_q + 1'b1)) state_d = vpa_pkg::S_SPLIT;
      end
      vpa_pkg::S_SPLIT:  state_d = vpa_pkg::S_WRPICK;
      vpa_pkg::S_WRPICK: state_d = vpa_pkg::S_IDLE;
      vpa_pkg::S_RCUR: begin
        if (!r_busy) state_d = vpa_pkg::S_IDLE;
        else if (CNTW'(idx_q) < last_idx) state_d = vpa_pkg::S_RNXT;
        else if (idx_q != '0) state_d = vpa_pkg::S_RPRV;
        else state_d = vpa_pkg::S_MERGE;
      end
      vpa_pkg::S_RNXT: begin
        state_d = (idx_q != '0) ? vpa_pkg::S_RPRV : vpa_pkg::S_MERGE;
      end
      vpa_pkg::S_RPRV: state_d = vpa_pkg::S_MERGE;
      vpa_pkg::S_MERGE: begin
        state_d = ((r_q != '0) && (sh_src < count_q)) ? vpa_pkg::S_SHDN : vpa_pkg::S_IDLE;
      end
      vpa_pkg::S_SHDN: begin
        if (CNTW'(k_q) == last_idx) state_d = vpa_pkg::S_IDLE;
      end
      default: state_d = vpa_pkg::S_IDLE;
    endcase
  end

  // Datapath, table access and results
  always_comb begin
    init_d   = init_q;
    count_d  = count_q;
    req_d    = req_q;
    owner_d  = owner_q;
    idx_d    = idx_q;
    k_d      = k_q;
    found_d  = found_q;
    pick_d   = pick_q;
    bstart_d = bstart_q;
    blen_d   = blen_q;
    cstart_d = cstart_q;
    clen_d   = clen_q;
    nb_d     = nb_q;
    nlen_d   = nlen_q;
    pb_d     = pb_q;
    plen_d   = plen_q;
    pstart_d = pstart_q;
    r_d      = r_q;
    done_d   = 1'b0;
    st_d     = st_q;
    sidx_d   = sidx_q;
    sstart_d = sstart_q;
    slen_d   = slen_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = '0;

    unique case (state_q)
      vpa_pkg::S_IDLE: begin
        if (init_q) begin
          // Set up the single free segment covering the whole memory.
          we      = 1'b1;
          waddr   = '0;
          wdata   = {OW'(0), 1'b0, total_q, AW'(0)};
          count_d = CNTW'(1);
          init_d  = 1'b0;
        end
        if (cfg_we_i && (cfg_idx_i == vpa_pkg::RegTotalSize)) begin
          init_d = 1'b1;
        end
        if (accept) begin
          req_d   = request_length_i;
          owner_d = owner_id_i;
          idx_d   = IW'(partition_index_i);
          found_d = 1'b0;
          k_d     = '0;
          raddr   = '0;
          nb_d    = 1'b0;
          pb_d    = 1'b0;
          if (operation_i == vpa_pkg::OpAlloc) begin
            if (request_length_i == '0) begin
              done_d = 1'b1;
              st_d   = vpa_pkg::StNoFit;
              sidx_d = '0; sstart_d = '0; slen_d = '0;
            end
          end else if (XW'(partition_index_i) >= XW'(count_q)) begin
            done_d = 1'b1;
            st_d   = vpa_pkg::StBadIndex;
            sidx_d = '0; sstart_d = '0; slen_d = '0;
          end else begin
            raddr = IW'(partition_index_i);
          end
        end
      end
      vpa_pkg::S_SCAN: begin
        if (take) begin
          found_d  = 1'b1;
          pick_d   = k_q;
          bstart_d = r_start;
          blen_d   = r_len;
        end
        k_d   = IW'(k_q + 1'b1);
        raddr = IW'(k_q + 1'b1);
      end
      vpa_pkg::S_DECIDE: begin
        sidx_d = '0; sstart_d = '0; slen_d = '0;
        if (!found_q || (CW'(blen_q) < reqx)) begin
          done_d = 1'b1;
          st_d   = vpa_pkg::StNoFit;
        end else if ((CW'(blen_q) > reqx) && (count_q >= CNTW'(MAX_SEGMENTS))) begin
          done_d = 1'b1;
          st_d   = vpa_pkg::StFull;
        end
        // Start the upward shift at the top entry.
        k_d   = IW'(last_idx);
        raddr = IW'(last_idx);
      end
      vpa_pkg::S_SHUP: begin
        we    = 1'b1;
        waddr = IW'(k_q + 1'b1);
        wdata = rdata;
        k_d   = IW'(k_q - 1'b1);
        raddr = IW'(k_q - 1'b1);
      end
      vpa_pkg::S_SPLIT: begin
        we      = 1'b1;
        waddr   = IW'(pick_q + 1'b1);
        wdata   = {OW'(0), 1'b0, AW'(CW'(blen_q) - reqx), AW'(CW'(bstart_q) + reqx)};
        count_d = count_q + 1'b1;
      end
      vpa_pkg::S_WRPICK: begin
        we       = 1'b1;
        waddr    = pick_q;
        wdata    = {owner_q, 1'b1, AW'(req_q), bstart_q};
        done_d   = 1'b1;
        st_d     = vpa_pkg::StOk;
        sidx_d   = vpa_pkg::PIdxW'(pick_q);
        sstart_d = vpa_pkg::LenW'(bstart_q);
        slen_d   = vpa_pkg::LenW'(AW'(req_q));
      end
      vpa_pkg::S_RCUR: begin
        cstart_d = r_start;
        clen_d   = r_len;
        if (!r_busy) begin
          done_d = 1'b1;
          st_d   = vpa_pkg::StFree;
          sidx_d = '0; sstart_d = '0; slen_d = '0;
        end
        raddr = (CNTW'(idx_q) < last_idx) ? IW'(idx_q + 1'b1) : IW'(idx_q - 1'b1);
      end
      vpa_pkg::S_RNXT: begin
        nb_d   = !r_busy;
        nlen_d = r_len;
        raddr  = IW'(idx_q - 1'b1);
      end
      vpa_pkg::S_RPRV: begin
        pb_d     = !r_busy;
        plen_d   = r_len;
        pstart_d = r_start;
        r_d      = 2'(nb_q) + 2'(!r_busy);
      end
      vpa_pkg::S_MERGE: begin
        we       = 1'b1;
        waddr    = pb_q ? IW'(idx_q - 1'b1) : idx_q;
        wdata    = {OW'(0), 1'b0, mlen, pb_q ? pstart_q : cstart_q};
        done_d   = 1'b1;
        st_d     = vpa_pkg::StOk;
        sidx_d   = vpa_pkg::PIdxW'(waddr);
        sstart_d = vpa_pkg::LenW'(pb_q ? pstart_q : cstart_q);
        slen_d   = vpa_pkg::LenW'(mlen);
        k_d      = IW'(sh_src);
        raddr    = IW'(sh_src);
        if ((r_q != '0) && (sh_src < count_q)) begin
          // Hold the result until the table is compacted.
          done_d = 1'b0;
        end else begin
          count_d = count_q - CNTW'(r_q);
        end
      end
      vpa_pkg::S_SHDN: begin
        we    = 1'b1;
        waddr = IW'(k_q - IW'(r_q));
        wdata = rdata;
        k_d   = IW'(k_q + 1'b1);
        raddr = IW'(k_q + 1'b1);
        if (CNTW'(k_q) == last_idx) begin
          done_d  = 1'b1;
          count_d = count_q - CNTW'(r_q);
        end
      end
      default: ;
    endcase

    // Release without a reachable previous entry: set merge width here.
    if ((state_q == vpa_pkg::S_RCUR) && (idx_q == '0) && (CNTW'(idx_q) >= last_idx)) begin
      r_d = '0;
    end
    if ((state_q == vpa_pkg::S_RNXT) && (idx_q == '0)) begin
      r_d = 2'(!r_busy);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vpa_pkg::S_IDLE;
      total_q  <= AW'(vpa_pkg::TotalSizeRst);
      policy_q <= vpa_pkg::PolFirst;
      init_q   <= 1'b1;
      count_q  <= CNTW'(1);
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == vpa_pkg::RegTotalSize) begin
          total_q <= AW'(cfg_data_i);
        end else begin
          policy_q <= cfg_data_i[vpa_pkg::PolicyW-1:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    owner_q  <= owner_d;
    idx_q    <= idx_d;
    k_q      <= k_d;
    found_q  <= found_d;
    pick_q   <= pick_d;
    bstart_q <= bstart_d;
    blen_q   <= blen_d;
    cstart_q <= cstart_d;
    clen_q   <= clen_d;
    nb_q     <= nb_d;
    nlen_q   <= nlen_d;
    pb_q     <= pb_d;
    plen_q   <= plen_d;
    pstart_q <= pstart_d;
    r_q      <= r_d;
    st_q     <= st_d;
    sidx_q   <= sidx_d;
    sstart_q <= sstart_d;
    slen_q   <= slen_d;
  end

  assign done_o           = done_q;
  assign status_o         = st_q;
  assign segment_index_o  = sidx_q;
  assign segment_start_o  = sstart_q;
  assign segment_length_o = slen_q;

  // The table never becomes empty nor overflows.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNTW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // A result only follows an accepted transaction or ongoing work.
  a_done_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(accept || (state_q != vpa_pkg::S_IDLE)))
    else $error("result without transaction");

  // The upward shift never touches the chosen segment.
  a_shift_above_pick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vpa_pkg::S_SHUP) |-> (k_q > pick_q))
    else $error("shift reached chosen segment");

  // Back in idle after every finished transaction.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == vpa_pkg::S_IDLE))
    else $error("result while still busy");

endmodule

### verif/variable_partition_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_checker
// Watches the command, result and register write channels, keeps its own copy
// of the segment table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module variable_partition_allocator_checker
  import vpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [LenW-1:0]    cfg_data_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               operation_i,
  input  logic [LenW-1:0]    request_length_i,
  input  logic [OwnerW-1:0]  owner_id_i,
  input  logic [PIdxW-1:0]   partition_index_i,
  input  logic               done_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [PIdxW-1:0]   segment_index_i,
  input  logic [LenW-1:0]    segment_start_i,
  input  logic [LenW-1:0]    segment_length_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output logic               accepted_o
);

  localparam int unsigned NSeg = MaxSegmentsDef;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PIdxW-1:0]   index;
    logic [LenW-1:0]    start;
    logic [LenW-1:0]    length;
  } outcome_t;

  logic [LenW-1:0]    mem_size;
  logic [PolicyW-1:0] policy;
  logic [LenW-1:0]    tbl_start [NSeg];
  logic [LenW-1:0]    tbl_len   [NSeg];
  logic               tbl_busy  [NSeg];
  int unsigned        tbl_count;

  outcome_t    outcome_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = outcome_q.size();
  assign accepted_o   = (start_i && !busy_i) || done_i;

  function automatic outcome_t fail_outcome(logic [StatusW-1:0] st);
    outcome_t o;
    o = '0;
    o.status = st;
    return o;
  endfunction

  task automatic table_clear();
    for (int k = 0; k < NSeg; k++) begin
      tbl_start[k] = '0;
      tbl_len[k]   = '0;
      tbl_busy[k]  = 1'b0;
    end
    tbl_len[0] = mem_size;
    tbl_count  = 1;
  endtask

  task automatic drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k]   = tbl_len[k+1];
      tbl_busy[k]  = tbl_busy[k+1];
    end
    tbl_count--;
  endtask

  task automatic allocate(logic [LenW-1:0] req, output outcome_t o);
    int unsigned pick;
    bit found;
    pick = 0;
    found = 0;
    if (req == 0) begin
      o = fail_outcome(StNoFit);
      return;
    end
    for (int unsigned k = 0; k < tbl_count; k++) begin
      if (tbl_busy[k]) continue;
      if (policy == PolWorst) begin
        if (!found || tbl_len[k] > tbl_len[pick]) begin
          pick = k;
          found = 1;
        end
      end else if (tbl_len[k] >= req) begin
        if (!found) begin
          pick = k;
          found = 1;
          if (policy != PolBest) break;
        end else if (tbl_len[k] < tbl_len[pick]) begin
          pick = k;
        end
      end
    end
    if (!found || tbl_len[pick] < req) begin
      o = fail_outcome(StNoFit);
      return;
    end
    if (tbl_len[pick] > req) begin
      if (tbl_count >= NSeg) begin
        o = fail_outcome(StFull);
        return;
      end
      for (int unsigned k = tbl_count; k > pick + 1; k--) begin
        tbl_start[k] = tbl_start[k-1];
        tbl_len[k]   = tbl_len[k-1];
        tbl_busy[k]  = tbl_busy[k-1];
      end
      tbl_start[pick+1] = tbl_start[pick] + req;
      tbl_len[pick+1]   = tbl_len[pick] - req;
      tbl_busy[pick+1]  = 1'b0;
      tbl_count++;
      tbl_len[pick] = req;
    end
    tbl_busy[pick] = 1'b1;
    o = '{StOk, PIdxW'(pick), tbl_start[pick], tbl_len[pick]};
  endtask

  task automatic release_seg(int unsigned idx, output outcome_t o);
    if (idx >= tbl_count) begin
      o = fail_outcome(StBadIndex);
      return;
    end
    if (!tbl_busy[idx]) begin
      o = fail_outcome(StFree);
      return;
    end
    tbl_busy[idx] = 1'b0;
    if (idx + 1 < tbl_count && !tbl_busy[idx+1]) begin
      tbl_len[idx] = tbl_len[idx] + tbl_len[idx+1];
      drop_entry(idx + 1);
    end
    if (idx > 0 && !tbl_busy[idx-1]) begin
      tbl_len[idx-1] = tbl_len[idx-1] + tbl_len[idx];
      drop_entry(idx);
      idx--;
    end
    o = '{StOk, PIdxW'(idx), tbl_start[idx], tbl_len[idx]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t o;
    outcome_t got;
    if (!rst_ni) begin
      mem_size = TotalSizeRst;
      policy   = PolFirst;
      table_clear();
      outcome_q.delete();
      fails = 0;
    end else begin
      // Compare before predicting: a result never belongs to the command
      // accepted at the same edge.
      if (done_i) begin
        got = '{status_i, segment_index_i, segment_start_i, segment_length_i};
        if (outcome_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %h", got);
        end else begin
          o = outcome_q.pop_front();
          if (got != o) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp st=%0d idx=%0d start=%0d len=%0d, got st=%0d idx=%0d start=%0d len=%0d",
                       o.status, o.index, o.start, o.length,
                       got.status, got.index, got.start, got.length);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == RegTotalSize) begin
          mem_size = cfg_data_i;
          table_clear();
        end else begin
          policy = cfg_data_i[PolicyW-1:0];
        end
      end
      if (start_i && !busy_i) begin
        if (operation_i == OpAlloc) allocate(request_length_i, o);
        else release_seg(partition_index_i, o);
        outcome_q.push_back(o);
      end
    end
  end

endmodule

### verif/variable_partition_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_tb
// Drives directed and random allocate/release transactions through several
// memory sizes and fit policies; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module variable_partition_allocator_tb;
  import vpa_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_idx;
  logic [LenW-1:0]    cfg_data;
  logic               start;
  logic               busy;
  logic               operation;
  logic [LenW-1:0]    request_length;
  logic [OwnerW-1:0]  owner_id;
  logic [PIdxW-1:0]   partition_index;
  logic               done;
  logic [StatusW-1:0] status;
  logic [PIdxW-1:0]   segment_index;
  logic [LenW-1:0]    segment_start;
  logic [LenW-1:0]    segment_length;
  int unsigned        fail_count;
  int unsigned        pending;
  logic               accepted;
  int unsigned        idle_pct;
  int unsigned        quiet_cycles;
  logic [LenW-1:0]    cur_size;

  variable_partition_allocator u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .start_i(start), .busy_o(busy),
    .operation_i(operation), .request_length_i(request_length),
    .owner_id_i(owner_id), .partition_index_i(partition_index),
    .done_o(done), .status_o(status), .segment_index_o(segment_index),
    .segment_start_o(segment_start), .segment_length_o(segment_length)
  );

  variable_partition_allocator_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .start_i(start), .busy_i(busy),
    .operation_i(operation), .request_length_i(request_length),
    .owner_id_i(owner_id), .partition_index_i(partition_index),
    .done_i(done), .status_i(status), .segment_index_i(segment_index),
    .segment_start_i(segment_start), .segment_length_i(segment_length),
    .fail_count_o(fail_count), .pending_o(pending), .accepted_o(accepted)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Watchdog: end the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || accepted || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("[variable_partition_allocator] ERROR");
      $finish;
    end
  end

  // Issue one transaction: drop start during a random gap that follows the
  // current idle percentage, then hold start until the block takes it.
  // Start stays high after the accepting edge; the next issue or drain
  // drives it in the same time step.
  task automatic issue(logic op, logic [LenW-1:0] len, logic [OwnerW-1:0] own,
                       logic [PIdxW-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    operation       <= op;
    request_length  <= len;
    owner_id        <= own;
    partition_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Wait until the block is idle and every result is in, then wait on
  // to cover the longest latency.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [LenW-1:0] val);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegTotalSize) cur_size = val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Mostly sized requests that fit a fraction of the memory, plus releases of
  // likely live indexes, with a sprinkle of zero lengths and wild values.
  task automatic random_burst(int unsigned count);
    logic [LenW-1:0] len;
    int unsigned     span;
    for (int unsigned n = 0; n < count; n++) begin
      span = (cur_size < 4) ? 4 : cur_size / 4;
      case ($urandom_range(9))
        0: len = LenW'($urandom);
        1: len = ($urandom_range(1)) ? '0 : 16'hFFFF;
        default: len = LenW'($urandom_range(span, 1));
      endcase
      if ($urandom_range(99) < 55)
        issue(OpAlloc, len, OwnerW'($urandom), PIdxW'($urandom));
      else
        issue(OpRelease, LenW'($urandom), OwnerW'($urandom),
              ($urandom_range(9) == 0) ? PIdxW'($urandom) : PIdxW'($urandom_range(12)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = RegTotalSize; cfg_data = '0;
    start = 1'b0; operation = OpAlloc; request_length = '0;
    owner_id = '0; partition_index = '0;
    idle_pct = 0; cur_size = TotalSizeRst;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: extremes, every status, merges on both sides.
    issue(OpAlloc, '0, 8'h00, '0);          // zero length
    issue(OpAlloc, 16'hFFFF, 8'hFF, '0);    // exact fit of whole memory
    issue(OpAlloc, 16'd1, 8'h01, '0);       // nothing free
    issue(OpRelease, '0, '0, 5'd1);         // bad index
    issue(OpRelease, '0, '0, 5'd0);         // release whole
    issue(OpRelease, '0, '0, 5'd0);         // already free
    issue(OpAlloc, 16'd100, 8'hA5, '0);
    issue(OpAlloc, 16'd200, 8'h5A, '0);
    issue(OpAlloc, 16'd300, 8'h11, '0);
    issue(OpRelease, '0, '0, 5'd0);
    issue(OpRelease, '0, '0, 5'd1);         // merge with lower neighbor
    issue(OpRelease, '0, '0, 5'd1);         // merge into both
    issue(OpRelease, '0, '0, 5'd31);

    // Fill the table with unit segments to hit the full-table split case.
    write_reg(RegTotalSize, 16'd40);
    for (int k = 0; k < 33; k++) issue(OpAlloc, 16'd1, OwnerW'(k), '0);
    issue(OpRelease, '0, '0, 5'd3);
    issue(OpAlloc, 16'd1, 8'h33, '0);       // exact fit with full table

    write_reg(RegTotalSize, '0);            // zero-size memory
    issue(OpAlloc, 16'd1, '0, '0);
    issue(OpRelease, '0, '0, '0);

    // Random phases over sizes and policies, extremes included.
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(RegFitPolicy, LenW'(phase % 4));
      case (phase % 4)
        0: write_reg(RegTotalSize, 16'hFFFF);
        1: write_reg(RegTotalSize, 16'd1);
        2: write_reg(RegTotalSize, LenW'($urandom_range(64, 8)));
        default: write_reg(RegTotalSize, LenW'($urandom_range(16'hFFFF, 1)));
      endcase
      idle_pct = (phase < 4) ? 11 : (phase < 8) ? 49 : 0;
      random_burst(80);
      if (phase == 5) begin
        // Hold off until every outstanding result has come back.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        random_burst(5);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("[variable_partition_allocator] OK");
    end else begin
      $display("[variable_partition_allocator] ERROR");
    end
    $finish;
  end

endmodule
